// ===== rtl/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared constants, controller states and control/status bundles for the
// k-max pooling row block.
// ----------------------------------------------------------------------------
package kmp_pkg;

    localparam int ROW_MAX_DEF = 1024;
    localparam int K_MAX_DEF   = 64;

    localparam int SAMPLE_W    = 16;
    localparam int COL_W       = 10;
    localparam int KEEP_W      = 7;
    localparam int OUT_TDATA_W = 32;

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RANK,
        ST_READ,
        ST_TEST,
        ST_SHORT
    } kmp_state_t;

    typedef struct packed {
        logic load;
        logic rank;
        logic rd;
        logic emit;
        logic emit_short;
    } kmp_cmd_t;

    typedef struct packed {
        logic short_row;
        logic hit;
        logic last_hit;
        logic out_free;
    } kmp_stat_t;

endpackage

// ===== rtl/k_max_pooling_row.sv =====
// ----------------------------------------------------------------------------
// k_max_pooling_row
// Keeps the k largest values of each row and returns them in column order.
// ----------------------------------------------------------------------------
// Samples stream in one per cycle while the block loads a row: each, up to
// ROW_MAX, is stored in the row memory and ranked into a sorted list of the
// K_MAX largest values in the same cycle. After the beat with tlast, the rank
// state picks the k-th largest value as threshold, then the stored row is
// scanned in column order, each column read from memory and then compared.
// Results leave through an output register, so the next row starts loading
// while the last result still waits to be taken. A row shorter than k gives a
// single beat with tuser set. No clearing pass is needed after reset.
module k_max_pooling_row #(
    parameter int ROW_MAX = kmp_pkg::ROW_MAX_DEF,
    parameter int K_MAX   = kmp_pkg::K_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [kmp_pkg::SAMPLE_W-1:0]    s_axis_tdata,  // [15:0] sample
    input  logic                            s_axis_tlast,  // row_end
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [kmp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [15:0] kept_value, [25:16] column
    output logic                            m_axis_tlast,  // final_res
    output logic                            m_axis_tuser,  // short_row
    input  logic                            k_keep_we,
    input  logic [kmp_pkg::KEEP_W-1:0]      k_keep_wdata
);

    kmp_pkg::kmp_cmd_t  cmd;
    kmp_pkg::kmp_stat_t stat;

    kmp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    kmp_datapath #(
        .ROW_MAX (ROW_MAX),
        .K_MAX   (K_MAX)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .sample        ($signed(s_axis_tdata)),
        .k_keep_we     (k_keep_we),
        .k_keep_wdata  (k_keep_wdata),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== rtl/kmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// kmp_ctrl
// Controller: sequences row load, threshold pick, column scan and emit.
// ----------------------------------------------------------------------------
module kmp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tlast,
    output logic              s_axis_tready,
    input  kmp_pkg::kmp_stat_t stat,
    output kmp_pkg::kmp_cmd_t  cmd
);

    kmp_pkg::kmp_state_t state_reg;
    kmp_pkg::kmp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kmp_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kmp_pkg::ST_LOAD:
            begin
                if (s_axis_tvalid && s_axis_tlast)
                begin
                    state_next = kmp_pkg::ST_RANK;
                end
            end
            kmp_pkg::ST_RANK:
            begin
                state_next = stat.short_row ? kmp_pkg::ST_SHORT : kmp_pkg::ST_READ;
            end
            kmp_pkg::ST_READ:
            begin
                state_next = kmp_pkg::ST_TEST;
            end
            kmp_pkg::ST_TEST:
            begin
                if (!stat.hit)
                begin
                    state_next = kmp_pkg::ST_READ;
                end
                else if (stat.out_free)
                begin
                    state_next = stat.last_hit ? kmp_pkg::ST_LOAD : kmp_pkg::ST_READ;
                end
            end
            kmp_pkg::ST_SHORT:
            begin
                if (stat.out_free)
                begin
                    state_next = kmp_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = kmp_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            kmp_pkg::ST_LOAD:
            begin
                s_axis_tready = 1'b1;
                cmd.load      = s_axis_tvalid;
            end
            kmp_pkg::ST_RANK:
            begin
                cmd.rank = 1'b1;
            end
            kmp_pkg::ST_READ:
            begin
                cmd.rd = 1'b1;
            end
            kmp_pkg::ST_TEST:
            begin
                cmd.emit = stat.hit && stat.out_free;
            end
            kmp_pkg::ST_SHORT:
            begin
                cmd.emit_short = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/kmp_datapath.sv =====
// ----------------------------------------------------------------------------
// kmp_datapath
// Row memory, sorted top-k register list, threshold, scan counters and the
// output register.
// ----------------------------------------------------------------------------
module kmp_datapath #(
    parameter int ROW_MAX = kmp_pkg::ROW_MAX_DEF,
    parameter int K_MAX   = kmp_pkg::K_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  kmp_pkg::kmp_cmd_t                 cmd,
    output kmp_pkg::kmp_stat_t                stat,
    input  logic signed [kmp_pkg::SAMPLE_W-1:0] sample,
    input  logic                              k_keep_we,
    input  logic [kmp_pkg::KEEP_W-1:0]        k_keep_wdata,
    input  logic                              m_axis_tready,
    output logic                              m_axis_tvalid,
    output logic [kmp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast,
    output logic                              m_axis_tuser
);

    localparam int AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
    localparam int FW = $clog2(ROW_MAX + 1);
    localparam int KW = $clog2(K_MAX + 1);
    localparam int LW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int SW = kmp_pkg::SAMPLE_W;
    localparam int CW = kmp_pkg::COL_W;

    logic signed [SW-1:0] row_mem [ROW_MAX];

    logic [FW-1:0]          fill_reg;
    logic signed [SW-1:0]   top_reg [K_MAX];
    logic [K_MAX-1:0]       top_vld_reg;
    logic signed [SW-1:0]   top_next [K_MAX];
    logic [K_MAX-1:0]       top_vld_next;
    logic [K_MAX-1:0]       beats;
    logic [kmp_pkg::KEEP_W-1:0] k_keep_reg;
    logic [KW-1:0]          k_eff;
    logic [KW-1:0]          k_reg;
    logic signed [SW-1:0]   c_reg;
    logic [AW-1:0]          j_reg;
    logic [KW-1:0]          n_reg;
    logic signed [SW-1:0]   rd_data_reg;
    logic [AW-1:0]          rd_col_reg;
    logic                   store_en;
    logic [LW-1:0]          k_idx;
    logic [CW-1:0]          rd_col;

    logic                   out_valid_reg;
    logic signed [SW-1:0]   out_value_reg;
    logic [CW-1:0]          out_col_reg;
    logic                   out_last_reg;
    logic                   out_short_reg;

    assign store_en = cmd.load && (fill_reg < FW'(ROW_MAX));

    // clamp k to 1..K_MAX
    always_comb
    begin
        if (k_keep_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (k_keep_reg > kmp_pkg::KEEP_W'(K_MAX))
        begin
            k_eff = KW'(K_MAX);
        end
        else
        begin
            k_eff = KW'(k_keep_reg);
        end
    end

    assign k_idx = LW'(k_eff - KW'(1));

    // parallel insert: entries that beat the sample hold, the first loser
    // takes the sample, the rest shift down one place
    genvar gi;
    generate
        for (gi = 0; gi < K_MAX; gi++)
        begin : g_top
            assign beats[gi] = top_vld_reg[gi] && (top_reg[gi] >= sample);
            if (gi == 0)
            begin : g_head
                assign top_next[gi]     = beats[gi] ? top_reg[gi] : sample;
                assign top_vld_next[gi] = 1'b1;
            end
            else
            begin : g_body
                assign top_next[gi]     = beats[gi]     ? top_reg[gi] :
                                          beats[gi-1]   ? sample : top_reg[gi-1];
                assign top_vld_next[gi] = top_vld_reg[gi] | top_vld_reg[gi-1];
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            row_mem[fill_reg[AW-1:0]] <= sample;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= row_mem[j_reg];
            rd_col_reg  <= j_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            for (int i = 0; i < K_MAX; i++)
            begin
                top_reg[i] <= top_next[i];
            end
        end
        if (cmd.rank)
        begin
            k_reg <= k_eff;
            c_reg <= top_reg[k_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            top_vld_reg <= '0;
            k_keep_reg  <= kmp_pkg::KEEP_RESET;
            j_reg       <= '0;
            n_reg       <= '0;
        end
        else
        begin
            if (k_keep_we)
            begin
                k_keep_reg <= k_keep_wdata;
            end
            if (cmd.rank)
            begin
                fill_reg    <= '0;
                top_vld_reg <= '0;
                j_reg       <= '0;
                n_reg       <= '0;
            end
            else
            begin
                if (store_en)
                begin
                    fill_reg    <= fill_reg + FW'(1);
                    top_vld_reg <= top_vld_next;
                end
                if (cmd.rd)
                begin
                    j_reg <= j_reg + AW'(1);
                end
                if (cmd.emit)
                begin
                    n_reg <= n_reg + KW'(1);
                end
            end
        end
    end

    assign rd_col = CW'(rd_col_reg);

    // output register: hold until taken, reload in the same cycle it drains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.emit_short)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_value_reg <= rd_data_reg;
            out_col_reg   <= rd_col;
            out_last_reg  <= stat.last_hit;
            out_short_reg <= 1'b0;
        end
        else if (cmd.emit_short)
        begin
            out_value_reg <= '0;
            out_col_reg   <= '0;
            out_last_reg  <= 1'b1;
            out_short_reg <= 1'b1;
        end
    end

    assign stat.short_row = {1'b0, fill_reg} < (FW + 1)'(k_eff);
    assign stat.hit       = rd_data_reg >= c_reg;
    assign stat.last_hit  = (n_reg == (k_reg - KW'(1)));
    assign stat.out_free  = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = kmp_pkg::OUT_TDATA_W'({out_col_reg, out_value_reg});
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_short_reg;

endmodule

// ===== rtl/kmp_checker.sv =====
// ----------------------------------------------------------------------------
// kmp_checker
// Port-level checks for the k-max pooling row block, bound to the top level.
// ----------------------------------------------------------------------------
module kmp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [kmp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast,
    input logic                            m_axis_tuser
);

    // a short-row beat is always the only, and so the last, beat of its row
    a_short_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("short-row beat without tlast");

    a_short_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("short-row beat carries data");

    // input drops ready in the cycle after a row has ended
    a_row_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input ready right after row end");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

endmodule

bind k_max_pooling_row kmp_checker u_kmp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
